// File: rtl/rapl_pkg.sv
// rapl_pkg: widths, constants and shared types of the region adjacency pair list
// used by the modules under rtl other than rapl_sdp_ram; depends on nothing
`default_nettype none

package rapl_pkg;

  // label and image geometry
  localparam int LABEL_W    = 8;
  localparam int LINE_DEPTH = 2048;
  localparam int COL_W      = $clog2(LINE_DEPTH);
  localparam int CFG_W      = 12;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 12'd640;
  localparam logic [CFG_W-1:0] WIDTH_MIN   = 12'd2;
  localparam logic [CFG_W-1:0] WIDTH_MAX   = 12'd2048;

  // seen-pair bitmap: one bit per (low, high), 64 bits per word
  localparam int BM_BITS   = 64;
  localparam int BIT_SEL_W = $clog2(BM_BITS);
  localparam int BM_DEPTH  = (1 << (2 * LABEL_W)) / BM_BITS;
  localparam int BM_ADDR_W = $clog2(BM_DEPTH);

  // frame epoch tag kept beside each bitmap word; zero marks a swept word
  localparam int EPOCH_W = 4;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 4'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 4'd15;
  localparam int BM_WORD_W = EPOCH_W + BM_BITS;

  // results
  localparam int PAIR_NUM_W  = 15;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 32;

  // which neighbor a pair slot compares against
  typedef enum logic {
    SLOT_LEFT  = 1'b0,
    SLOT_UPPER = 1'b1
  } slot_kind_t;

  // one pair slot issued from the front end to the bitmap unit
  typedef struct packed {
    logic                valid;
    slot_kind_t          kind;
    logic                act;
    logic [LABEL_W-1:0]  lo;
    logic [LABEL_W-1:0]  hi;
    logic                fs;
    logic [EPOCH_W-1:0]  epoch;
  } slot_t;

  // one result item
  typedef struct packed {
    logic                  last;
    logic [PAIR_NUM_W-1:0] num;
    logic [LABEL_W-1:0]    hi;
    logic [LABEL_W-1:0]    lo;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/rapl_sdp_ram.sv
// rapl_sdp_ram: generic simple dual-port ram, one write and one registered read per cycle
// read of an address written in the same cycle returns the old data; no dependencies
`default_nettype none

module rapl_sdp_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // storage with registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rapl_front.sv
// rapl_front: pixel intake, column and row tracking, line store and pair slot issue
// depends on rapl_pkg and rapl_sdp_ram
`default_nettype none

module rapl_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [rapl_pkg::CFG_W-1:0]     cfg_width,
  input  wire logic                           in_valid,
  input  wire logic [rapl_pkg::LABEL_W-1:0]   in_label,
  input  wire logic                           in_fs,
  output logic                                in_ready,
  input  wire logic                           adv,
  input  wire logic                           sweep_block,
  output rapl_pkg::slot_t                     slot,
  output logic                                req_sweep,
  output logic                                busy
);

  logic [rapl_pkg::COL_W-1:0]   col_r;
  logic                         first_r;
  logic [rapl_pkg::LABEL_W-1:0] left_r;
  logic [rapl_pkg::EPOCH_W-1:0] epoch_r;

  logic                         s1_valid_r;
  rapl_pkg::slot_kind_t         s1_phase_r;
  logic [rapl_pkg::LABEL_W-1:0] s1_label_r;
  logic [rapl_pkg::LABEL_W-1:0] s1_left_r;
  logic                         s1_do_r;
  logic                         s1_fs_r;
  logic [rapl_pkg::EPOCH_W-1:0] s1_epoch_r;

  logic                         accept;
  logic                         issue;
  logic [rapl_pkg::CFG_W-1:0]   w_eff;
  logic [rapl_pkg::COL_W-1:0]   col;
  logic                         first;
  logic                         col_end;
  logic [rapl_pkg::LABEL_W-1:0] upper;
  logic [rapl_pkg::LABEL_W-1:0] nb;

  // handshake: a pixel enters once the held one issues its second slot
  assign in_ready = adv && !sweep_block &&
                    (!s1_valid_r || s1_phase_r == rapl_pkg::SLOT_UPPER);
  assign accept   = in_valid && in_ready;
  assign issue    = s1_valid_r && adv;
  assign busy     = s1_valid_r;
  assign req_sweep = accept && in_fs && (epoch_r == rapl_pkg::EPOCH_LAST);

  // effective width and row position of the incoming pixel
  always_comb begin
    if (cfg_width < rapl_pkg::WIDTH_MIN) begin
      w_eff = rapl_pkg::WIDTH_MIN;
    end else if (cfg_width > rapl_pkg::WIDTH_MAX) begin
      w_eff = rapl_pkg::WIDTH_MAX;
    end else begin
      w_eff = cfg_width;
    end
    col     = in_fs ? '0 : col_r;
    first   = in_fs ? 1'b1 : first_r;
    col_end = ({1'b0, col} + rapl_pkg::CFG_W'(1)) >= w_eff;
  end

  // previous row labels, read and overwritten at the same column
  rapl_sdp_ram #(
    .DEPTH (rapl_pkg::LINE_DEPTH),
    .WIDTH (rapl_pkg::LABEL_W)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col),
    .wr_data (in_label),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (upper)
  );

  // raster position, left neighbor and frame epoch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      first_r <= 1'b1;
      left_r  <= '0;
      epoch_r <= rapl_pkg::EPOCH_FIRST;
    end else if (accept) begin
      col_r   <= col_end ? '0 : col + rapl_pkg::COL_W'(1);
      first_r <= first && !col_end;
      left_r  <= in_label;
      if (in_fs) begin
        epoch_r <= (epoch_r == rapl_pkg::EPOCH_LAST) ? rapl_pkg::EPOCH_FIRST
                                                      : epoch_r + rapl_pkg::EPOCH_W'(1);
      end
    end
  end

  // held pixel: two slot phases, left pair then upper pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_phase_r <= rapl_pkg::SLOT_LEFT;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
      s1_phase_r <= rapl_pkg::SLOT_LEFT;
    end else if (issue) begin
      if (s1_phase_r == rapl_pkg::SLOT_LEFT) begin
        s1_phase_r <= rapl_pkg::SLOT_UPPER;
      end else begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // held pixel payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_label_r <= in_label;
      s1_left_r  <= left_r;
      s1_do_r    <= !first && (col != '0);
      s1_fs_r    <= in_fs;
      s1_epoch_r <= in_fs ? ((epoch_r == rapl_pkg::EPOCH_LAST) ? rapl_pkg::EPOCH_FIRST
                                                               : epoch_r + rapl_pkg::EPOCH_W'(1))
                          : epoch_r;
    end
  end

  // pair of the current slot, ordered low/high
  always_comb begin
    nb         = (s1_phase_r == rapl_pkg::SLOT_LEFT) ? s1_left_r : upper;
    slot.valid = issue;
    slot.kind  = s1_phase_r;
    slot.act   = s1_do_r && (nb != s1_label_r);
    slot.lo    = (nb < s1_label_r) ? nb : s1_label_r;
    slot.hi    = (nb < s1_label_r) ? s1_label_r : nb;
    slot.fs    = s1_fs_r && (s1_phase_r == rapl_pkg::SLOT_LEFT);
    slot.epoch = s1_epoch_r;
  end

endmodule

`default_nettype wire

// File: rtl/rapl_pair_unit.sv
// rapl_pair_unit: seen-pair bitmap read-modify-write with forwarding, epoch sweep,
// pair numbering and last-flag resolution; depends on rapl_pkg and rapl_sdp_ram
`default_nettype none

module rapl_pair_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rapl_pkg::slot_t    slot,
  input  wire logic               busy,
  input  wire logic               req_sweep,
  input  wire logic               adv,
  output logic                    sweep_block,
  output logic                    push,
  output rapl_pkg::result_t       push_item
);

  // bitmap port signals
  logic                           rd_en;
  logic [rapl_pkg::BM_ADDR_W-1:0] rd_addr;
  logic [rapl_pkg::BM_WORD_W-1:0] rd_data;
  logic                           wr_en;
  logic [rapl_pkg::BM_ADDR_W-1:0] wr_addr;
  logic [rapl_pkg::BM_WORD_W-1:0] wr_data;

  // sweep control
  logic                           sweep_pend_r;
  logic                           sweep_act_r;
  logic [rapl_pkg::BM_ADDR_W-1:0] sweep_cnt_r;
  logic                           sweep_start;

  // lookup stage
  logic                           s2_valid_r;
  rapl_pkg::slot_kind_t           s2_kind_r;
  logic                           s2_act_r;
  logic [rapl_pkg::LABEL_W-1:0]   s2_lo_r;
  logic [rapl_pkg::LABEL_W-1:0]   s2_hi_r;
  logic                           s2_fs_r;
  logic [rapl_pkg::EPOCH_W-1:0]   s2_epoch_r;

  // last write, for a read that overlapped it
  logic                           fwd_valid_r;
  logic [rapl_pkg::BM_ADDR_W-1:0] fwd_addr_r;
  logic [rapl_pkg::BM_WORD_W-1:0] fwd_word_r;

  logic [rapl_pkg::PAIR_NUM_W-1:0] pairs_found_r;

  // result stage
  logic                            s3_valid_r;
  rapl_pkg::slot_kind_t            s3_kind_r;
  logic                            s3_new_r;
  logic [rapl_pkg::LABEL_W-1:0]    s3_lo_r;
  logic [rapl_pkg::LABEL_W-1:0]    s3_hi_r;
  logic [rapl_pkg::PAIR_NUM_W-1:0] s3_num_r;

  logic [rapl_pkg::BM_ADDR_W-1:0]  s2_addr;
  logic [rapl_pkg::BIT_SEL_W-1:0]  s2_bsel;
  logic [rapl_pkg::BM_WORD_W-1:0]  s2_word;
  logic [rapl_pkg::BM_BITS-1:0]    s2_bits;
  logic                            s2_new;
  logic                            s2_write;

  // lookup address of the issued pair
  assign rd_en   = slot.valid && slot.act;
  assign rd_addr = {slot.lo, slot.hi[rapl_pkg::LABEL_W-1:rapl_pkg::BIT_SEL_W]};

  // seen test on forwarded or stored word; stale epoch reads as empty
  always_comb begin
    s2_addr  = {s2_lo_r, s2_hi_r[rapl_pkg::LABEL_W-1:rapl_pkg::BIT_SEL_W]};
    s2_bsel  = s2_hi_r[rapl_pkg::BIT_SEL_W-1:0];
    s2_word  = (fwd_valid_r && fwd_addr_r == s2_addr) ? fwd_word_r : rd_data;
    s2_bits  = (s2_word[rapl_pkg::BM_WORD_W-1:rapl_pkg::BM_BITS] == s2_epoch_r)
               ? s2_word[rapl_pkg::BM_BITS-1:0] : '0;
    s2_new   = s2_valid_r && s2_act_r && !s2_bits[s2_bsel];
    s2_write = s2_new && adv;
  end

  // write port: sweep has it alone, otherwise the marking of a new pair
  always_comb begin
    if (sweep_act_r) begin
      wr_en   = 1'b1;
      wr_addr = sweep_cnt_r;
      wr_data = '0;
    end else begin
      wr_en   = s2_write;
      wr_addr = s2_addr;
      wr_data = {s2_epoch_r,
                 s2_bits | (rapl_pkg::BM_BITS'(1) << s2_bsel)};
    end
  end

  rapl_sdp_ram #(
    .DEPTH (rapl_pkg::BM_DEPTH),
    .WIDTH (rapl_pkg::BM_WORD_W)
  ) u_bitmap_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // epoch sweep: after reset and when the epoch wraps, once the pipe is drained
  assign sweep_start = sweep_pend_r && !busy && !s2_valid_r;
  assign sweep_block = sweep_pend_r || sweep_act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_pend_r <= 1'b1;
      sweep_act_r  <= 1'b0;
      sweep_cnt_r  <= '0;
    end else begin
      if (req_sweep) begin
        sweep_pend_r <= 1'b1;
      end else if (sweep_start) begin
        sweep_pend_r <= 1'b0;
      end
      if (sweep_start) begin
        sweep_act_r <= 1'b1;
        sweep_cnt_r <= '0;
      end else if (sweep_act_r) begin
        sweep_cnt_r <= sweep_cnt_r + rapl_pkg::BM_ADDR_W'(1);
        if (sweep_cnt_r == rapl_pkg::BM_ADDR_W'(rapl_pkg::BM_DEPTH - 1)) begin
          sweep_act_r <= 1'b0;
        end
      end
    end
  end

  // pipeline control: stages move together on adv
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r    <= 1'b0;
      s3_valid_r    <= 1'b0;
      fwd_valid_r   <= 1'b0;
      pairs_found_r <= '0;
    end else if (adv) begin
      s2_valid_r  <= slot.valid;
      s3_valid_r  <= s2_valid_r;
      fwd_valid_r <= s2_write;
      if (s2_valid_r && s2_fs_r) begin
        pairs_found_r <= '0;
      end else if (s2_new) begin
        pairs_found_r <= pairs_found_r + rapl_pkg::PAIR_NUM_W'(1);
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kind_r  <= slot.kind;
      s2_act_r   <= slot.act;
      s2_lo_r    <= slot.lo;
      s2_hi_r    <= slot.hi;
      s2_fs_r    <= slot.fs;
      s2_epoch_r <= slot.epoch;
      fwd_addr_r <= s2_addr;
      fwd_word_r <= wr_data;
      s3_kind_r  <= s2_kind_r;
      s3_new_r   <= s2_new;
      s3_lo_r    <= s2_lo_r;
      s3_hi_r    <= s2_hi_r;
      s3_num_r   <= pairs_found_r;
    end
  end

  // a left pair is last unless the upper pair right behind it is new
  always_comb begin
    push           = adv && s3_valid_r && s3_new_r;
    push_item.lo   = s3_lo_r;
    push_item.hi   = s3_hi_r;
    push_item.num  = s3_num_r;
    push_item.last = (s3_kind_r == rapl_pkg::SLOT_UPPER) || !s2_new;
  end

  // no lookup may share the bitmap with the sweep
  assert property (@(posedge clk) disable iff (!rst_n) sweep_act_r |-> !rd_en)
    else $error("bitmap lookup during sweep");

  // a left pair result always has its upper pair one stage behind
  assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && s3_kind_r == rapl_pkg::SLOT_LEFT) |->
      (s2_valid_r && s2_kind_r == rapl_pkg::SLOT_UPPER))
    else $error("left pair result without its upper pair");

  // each new pair advances the running ordinal by one
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_new && !(s2_valid_r && s2_fs_r)) |=>
      pairs_found_r == $past(pairs_found_r) + rapl_pkg::PAIR_NUM_W'(1))
    else $error("pair ordinal did not advance");

endmodule

`default_nettype wire

// File: rtl/rapl_out_fifo.sv
// rapl_out_fifo: small result queue between the pair unit and the output channel
// depends on rapl_pkg
`default_nettype none

module rapl_out_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire rapl_pkg::result_t push_item,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rapl_pkg::result_t      out_item
);

  rapl_pkg::result_t               mem [rapl_pkg::FIFO_DEPTH];
  logic [rapl_pkg::FIFO_PTR_W-1:0] wr_ptr_r;
  logic [rapl_pkg::FIFO_PTR_W-1:0] rd_ptr_r;
  logic [rapl_pkg::FIFO_CNT_W-1:0] count_r;
  logic                            pop;

  assign full      = count_r == rapl_pkg::FIFO_CNT_W'(rapl_pkg::FIFO_DEPTH);
  assign out_valid = count_r != '0;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + rapl_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + rapl_pkg::FIFO_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + rapl_pkg::FIFO_CNT_W'(1);
        2'b01:   count_r <= count_r - rapl_pkg::FIFO_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/region_adjacency_pair_list.sv
// Region adjacency pair list, top level; depends on rapl_pkg, rapl_front,
// rapl_pair_unit and rapl_out_fifo.
// Flow: an accepted pixel is held while it issues its left then its upper pair slot, each
// through the lookup and result stages to the result queue; the next pixel enters as the
// upper slot issues, and all stalls while the queue is full. Reset: synchronous, active low;
// a bitmap sweep follows reset and every 15th frame start, with in_tready low meanwhile.
`default_nettype none

module region_adjacency_pair_list (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // pixel items
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [rapl_pkg::IN_DATA_W-1:0]   in_tdata,   // [7:0] pixel_label
  input  wire logic                             in_tuser,   // [0] frame_start
  // width register
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rapl_pkg::CFG_W-1:0]       cfg_data,   // [11:0] image_width
  // pair items
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [rapl_pkg::OUT_DATA_W-1:0]  out_tdata,  // [7:0] low_label,
                                                            // [15:8] high_label,
                                                            // [30:16] pair_number, [31] zero
  output logic                                  out_tlast   // last pair of the pixel
);

  logic [rapl_pkg::CFG_W-1:0] width_r;
  rapl_pkg::slot_t            slot;
  rapl_pkg::result_t          push_item;
  rapl_pkg::result_t          out_item;
  logic                       req_sweep;
  logic                       busy;
  logic                       sweep_block;
  logic                       push;
  logic                       full;
  logic                       adv;

  // width register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= rapl_pkg::WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      width_r <= cfg_data;
    end
  end

  // pipeline moves whenever the result queue has room
  assign adv = !full;

  rapl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_width   (width_r),
    .in_valid    (in_tvalid),
    .in_label    (in_tdata),
    .in_fs       (in_tuser),
    .in_ready    (in_tready),
    .adv         (adv),
    .sweep_block (sweep_block),
    .slot        (slot),
    .req_sweep   (req_sweep),
    .busy        (busy)
  );

  rapl_pair_unit u_pair_unit (
    .clk         (clk),
    .rst_n       (rst_n),
    .slot        (slot),
    .busy        (busy),
    .req_sweep   (req_sweep),
    .adv         (adv),
    .sweep_block (sweep_block),
    .push        (push),
    .push_item   (push_item)
  );

  rapl_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  // output packing
  assign out_tdata = {1'b0, out_item.num, out_item.hi, out_item.lo};
  assign out_tlast = out_item.last;

endmodule

`default_nettype wire
